// File: src/pms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants of the melody sequencer.
// ----------------------------------------------------------------------------
package pms_pkg;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_LOAD = 2'd1;
   localparam logic [1:0] FUNC_PLAY = 2'd2;
   localparam logic [1:0] FUNC_STOP = 2'd3;

   localparam logic [1:0] CSR_CLOCK  = 2'd0;
   localparam logic [1:0] CSR_VOLUME = 2'd1;
   localparam logic [1:0] CSR_ENABLE = 2'd2;
   localparam logic [1:0] CSR_MASK   = 2'd3;

   localparam logic [28:0] CLOCK_RESET  = 29'd120000000;
   localparam logic [6:0]  VOLUME_RESET = 7'd10;
   localparam logic [6:0]  VOLUME_MAX   = 7'd100;
   localparam logic [7:0]  DIV_MAX      = 8'd255;
   localparam logic [7:0]  DUTY_DIVISOR = 8'd200;

   // note memory size, addresses wrap at this depth
   localparam int NOTE_DEPTH = 64;
   localparam int NOTE_AW    = 6;

   // serial divider command and reply
   typedef struct packed {
      logic        start;
      logic [40:0] dividend;
      logic [40:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [40:0] quotient;
   } div_rsp_type;

   // serial multiplier command and reply
   typedef struct packed {
      logic        start;
      logic [31:0] a;
      logic [31:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic        done;
      logic [47:0] product;
   } mul_rsp_type;

endpackage

// File: src/pms_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pms_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pms_pkg::div_cmd_type cmd,
   output pms_pkg::div_rsp_type rsp
);

   logic [40:0] rem_ff, rem_in;
   logic [40:0] quo_ff, quo_in;
   logic [40:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [41:0] trial;

   // one shift and subtract step
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[40]} - {1'b0, dsr_ff};
      if (cmd.start) begin
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         cnt_in  = 6'd41;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[41]) begin
            rem_in = trial[40:0];
            quo_in = {quo_ff[39:0], 1'b1};
         end else begin
            rem_in = {rem_ff[39:0], quo_ff[40]};
            quo_in = {quo_ff[39:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: src/pms_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_multiplier
// Shift and add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pms_multiplier (
   input  logic                 clock,
   input  logic                 reset,
   input  pms_pkg::mul_cmd_type cmd,
   output pms_pkg::mul_rsp_type rsp
);

   logic [47:0] acc_ff, acc_in;
   logic [47:0] mcd_ff, mcd_in;
   logic [31:0] mpr_ff, mpr_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   // add the shifted multiplicand for each set bit
   always_comb begin
      acc_in  = acc_ff;
      mcd_in  = mcd_ff;
      mpr_in  = mpr_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         acc_in  = '0;
         mcd_in  = {16'd0, cmd.a};
         mpr_in  = cmd.b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mpr_ff[0]) acc_in = acc_ff + mcd_ff;
         mcd_in = {mcd_ff[46:0], 1'b0};
         mpr_in = {1'b0, mpr_ff[31:1]};
         if (mpr_ff[31:1] == 31'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      mpr_ff <= mpr_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// File: src/pwm_melody_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_melody_sequencer_core
// Melody sequencer giving PWM tone settings from a note memory.
// ----------------------------------------------------------------------------
// Each request gives one response, and the next request is taken only after
// that response has been accepted. Loads, stops, ignored plays and ticks that
// start no note use no serial unit; a rest runs only the note length
// multiply. A tick or play that starts a tone runs the bit-serial divider
// three times (the clock divider, the wrap and the duty over 200) and the
// shift-add multiplier twice (the volume, the note length); a tick that
// starts a delayed melody whose first note has zero length plays two notes
// in one request. The note memory has one read port with registered data
// and needs no clearing after reset.
module pwm_melody_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_note_index,
   input  logic [15:0] req_note_frequency,
   input  logic [15:0] req_note_duration,
   input  logic [6:0]  req_melody_length,
   input  logic [15:0] req_melody_tempo,
   input  logic [15:0] req_start_delay_ms,
   input  logic        req_delayed_start,
   input  logic [3:0]  req_sound_event,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tone_on,
   output logic [7:0]  rsp_pwm_clock_divider,
   output logic [15:0] rsp_pwm_wrap,
   output logic [15:0] rsp_pwm_duty,
   output logic        rsp_melody_playing,
   output logic        rsp_tone_changed,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [28:0] csr_data
);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_DECIDE = 12'b000000000010,
      S_READ   = 12'b000000000100,
      S_START  = 12'b000000001000,
      S_NOTE   = 12'b000000010000,
      S_DIV1   = 12'b000000100000,
      S_DIV2   = 12'b000001000000,
      S_DMUL   = 12'b000010000000,
      S_DDIV   = 12'b000100000000,
      S_LEN    = 12'b001000000000,
      S_ADV    = 12'b010000000000,
      S_RESP   = 12'b100000000000
   } state_type;

   state_type   state_ff;

   // configuration
   logic [28:0] clk_hz_ff;
   logic [6:0]  vol_ff;
   logic        en_ff;
   logic [15:0] mask_ff;

   // captured request
   logic [1:0]  func_ff;
   logic [5:0]  idx_ff;
   logic [15:0] tempo_ff, delay_ff;
   logic [6:0]  len_ff;
   logic        dly_ff;
   logic [3:0]  ev_ff;

   // sequencer state
   logic                        play_ff, pend_ff, chk_ff;
   logic [pms_pkg::NOTE_AW-1:0] base_ff, pbase_ff;
   logic [6:0]                  pos_ff, cnt_ff, pcnt_ff;
   logic [15:0]                 unit_ff, punit_ff, pleft_ff;
   logic [31:0]                 left_ff;

   // tone
   logic        on_ff, chg_ff;
   logic [7:0]  tdiv_ff;
   logic [15:0] twrap_ff, tduty_ff;
   logic [15:0] nfreq_ff, ndur_ff;
   logic        rsp_ff;

   // note memory
   logic [31:0]                 mem [pms_pkg::NOTE_DEPTH];
   logic [31:0]                 rd_ff;
   logic [pms_pkg::NOTE_AW-1:0] rd_addr;

   pms_pkg::div_cmd_type dcmd;
   pms_pkg::div_rsp_type drsp;
   pms_pkg::mul_cmd_type mcmd;
   pms_pkg::mul_rsp_type mrsp;

   logic [40:0] quo;
   logic [7:0]  div_clamp;
   logic [23:0] div_freq;
   logic [15:0] wrapv;
   logic [6:0]  pos_nx;

   pms_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .rsp(drsp));
   pms_multiplier u_mul (.clock(clock), .reset(reset), .cmd(mcmd), .rsp(mrsp));

   // quotient post-processing
   assign quo       = drsp.quotient;
   assign div_clamp = (quo == 41'd0) ? 8'd1
                    : (quo > {33'd0, pms_pkg::DIV_MAX}) ? pms_pkg::DIV_MAX : quo[7:0];
   assign div_freq  = {16'd0, div_clamp} * {8'd0, nfreq_ff};
   assign wrapv     = (quo == 41'd0 || quo > 41'd65536) ? 16'hFFFF : 16'(quo - 41'd1);
   assign pos_nx    = pos_ff + 7'd1;
   assign rd_addr   = base_ff + pos_ff[pms_pkg::NOTE_AW-1:0];

   // note memory, written on a load request
   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_func == pms_pkg::FUNC_LOAD)
         mem[req_note_index] <= {req_note_duration, req_note_frequency};
      rd_ff <= mem[rd_addr];
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_ff;

   // command launches for the serial units
   always_comb begin
      dcmd = '0;
      mcmd = '0;
      if (state_ff == S_NOTE && nfreq_ff != 16'd0) begin
         dcmd.start    = 1'b1;
         dcmd.dividend = {12'd0, clk_hz_ff};
         dcmd.divisor  = {13'd0, nfreq_ff, 12'd0};
      end
      if (state_ff == S_DIV1 && drsp.done) begin
         dcmd.start    = 1'b1;
         dcmd.dividend = {12'd0, clk_hz_ff};
         dcmd.divisor  = {17'd0, div_freq};
      end
      if (state_ff == S_DMUL && mrsp.done) begin
         dcmd.start    = 1'b1;
         dcmd.dividend = {18'd0, mrsp.product[22:0]};
         dcmd.divisor  = {33'd0, pms_pkg::DUTY_DIVISOR};
      end
      if (state_ff == S_DIV2 && drsp.done) begin
         mcmd.start = 1'b1;
         mcmd.a     = {16'd0, wrapv};
         mcmd.b     = {25'd0, vol_ff};
      end
      if ((state_ff == S_NOTE && nfreq_ff == 16'd0) || (state_ff == S_DDIV && drsp.done)) begin
         mcmd.start = 1'b1;
         mcmd.a     = {16'd0, ndur_ff};
         mcmd.b     = {16'd0, unit_ff};
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         clk_hz_ff <= pms_pkg::CLOCK_RESET;
         vol_ff    <= pms_pkg::VOLUME_RESET;
         en_ff     <= 1'b1;
         mask_ff   <= 16'hFFFF;
         play_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         chk_ff    <= 1'b0;
         base_ff   <= '0;
         pbase_ff  <= '0;
         pos_ff    <= '0;
         cnt_ff    <= '0;
         pcnt_ff   <= '0;
         unit_ff   <= '0;
         punit_ff  <= '0;
         pleft_ff  <= '0;
         left_ff   <= '0;
         on_ff     <= 1'b0;
         chg_ff    <= 1'b0;
         tdiv_ff   <= '0;
         twrap_ff  <= '0;
         tduty_ff  <= '0;
         rsp_ff    <= 1'b0;
      end else begin
         if (rsp_ff && rsp_ready) rsp_ff <= 1'b0;
         // configuration writes
         if (csr_write) begin
            unique case (csr_index)
               pms_pkg::CSR_CLOCK:  clk_hz_ff <= csr_data;
               pms_pkg::CSR_VOLUME: vol_ff <= (csr_data[6:0] > pms_pkg::VOLUME_MAX)
                                        ? pms_pkg::VOLUME_MAX : csr_data[6:0];
               pms_pkg::CSR_ENABLE: begin
                  en_ff <= csr_data[0];
                  if (!csr_data[0]) begin
                     on_ff <= 1'b0; tdiv_ff <= '0; tduty_ff <= '0;
                     play_ff <= 1'b0; pend_ff <= 1'b0;
                  end
               end
               pms_pkg::CSR_MASK:   mask_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               func_ff <= req_func; idx_ff <= req_note_index;
               len_ff <= req_melody_length; tempo_ff <= req_melody_tempo;
               delay_ff <= req_start_delay_ms; dly_ff <= req_delayed_start;
               ev_ff <= req_sound_event; chg_ff <= 1'b0; chk_ff <= 1'b0;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               unique case (func_ff)
                  pms_pkg::FUNC_TICK: begin
                     if (pleft_ff != 16'd0) pleft_ff <= pleft_ff - 16'd1;
                     if (play_ff && left_ff != 32'd0) left_ff <= left_ff - 32'd1;
                     if (!play_ff && pend_ff && pleft_ff <= 16'd1) begin
                        // delayed melody starts, then the tick's advance check
                        pend_ff <= 1'b0;
                        base_ff <= pbase_ff; cnt_ff <= pcnt_ff; unit_ff <= punit_ff;
                        pos_ff <= '0; play_ff <= 1'b1; left_ff <= '0;
                        if (pcnt_ff != 7'd0) begin
                           chk_ff   <= 1'b1;
                           state_ff <= S_READ;
                        end else begin
                           state_ff <= S_ADV;
                        end
                     end else if (play_ff && left_ff <= 32'd1) begin
                        state_ff <= S_ADV;
                     end else begin
                        state_ff <= S_RESP;
                     end
                  end
                  pms_pkg::FUNC_LOAD: state_ff <= S_RESP;
                  pms_pkg::FUNC_PLAY: begin
                     if (en_ff && mask_ff[ev_ff] && !dly_ff) begin
                        pend_ff <= 1'b0; base_ff <= idx_ff;
                        cnt_ff <= len_ff; unit_ff <= tempo_ff;
                        pos_ff <= '0; play_ff <= 1'b1; left_ff <= '0;
                        state_ff <= (len_ff != 7'd0) ? S_READ : S_RESP;
                     end else begin
                        if (en_ff && mask_ff[ev_ff]) begin
                           pend_ff <= 1'b1; pbase_ff <= idx_ff;
                           pcnt_ff <= len_ff; punit_ff <= tempo_ff;
                           pleft_ff <= delay_ff;
                        end
                        state_ff <= S_RESP;
                     end
                  end
                  default: begin
                     on_ff <= 1'b0; tdiv_ff <= '0; tduty_ff <= '0; chg_ff <= 1'b1;
                     play_ff <= 1'b0; pend_ff <= 1'b0;
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_ADV: begin
               chk_ff <= 1'b0;
               pos_ff <= pos_nx;
               if (pos_nx >= cnt_ff || pos_nx == 7'd0) begin
                  on_ff <= 1'b0; tdiv_ff <= '0; tduty_ff <= '0; chg_ff <= 1'b1;
                  play_ff <= 1'b0; pend_ff <= 1'b0;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_START;
            S_START: begin
               nfreq_ff <= rd_ff[15:0]; ndur_ff <= rd_ff[31:16];
               state_ff <= S_NOTE;
            end
            S_NOTE: begin
               chg_ff <= 1'b1;
               if (nfreq_ff == 16'd0) begin
                  on_ff <= 1'b0; tdiv_ff <= '0; tduty_ff <= '0;
                  state_ff <= S_LEN;
               end else begin
                  state_ff <= S_DIV1;
               end
            end
            S_DIV1: if (drsp.done) begin
               tdiv_ff  <= div_clamp;
               on_ff    <= 1'b1;
               state_ff <= S_DIV2;
            end
            S_DIV2: if (drsp.done) begin
               twrap_ff <= wrapv;
               state_ff <= S_DMUL;
            end
            S_DMUL: if (mrsp.done) state_ff <= S_DDIV;
            S_DDIV: if (drsp.done) begin
               tduty_ff <= (quo == 41'd0 && vol_ff != 7'd0) ? 16'd1 : quo[15:0];
               state_ff <= S_LEN;
            end
            S_LEN: if (mrsp.done) begin
               left_ff  <= mrsp.product[31:0];
               state_ff <= (chk_ff && mrsp.product[31:0] == 32'd0) ? S_ADV : S_RESP;
            end
            S_RESP: begin
               rsp_ff   <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_ff;
   assign rsp_tone_on           = on_ff;
   assign rsp_pwm_clock_divider = tdiv_ff;
   assign rsp_pwm_wrap          = twrap_ff;
   assign rsp_pwm_duty          = tduty_ff;
   assign rsp_melody_playing    = play_ff;
   assign rsp_tone_changed      = chg_ff;

   // a response only leaves when the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE) else $error("response outside idle");
   // no request is taken while a response waits
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during response");
   // tone off means zero divider
   a_off_div: assert property (@(posedge clock) disable iff (reset)
      !on_ff |-> tdiv_ff == 8'd0) else $error("divider set with tone off");

endmodule
